// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lrk_pkg.sv =====
// Types, widths and helper functions of the Lorenz RK4 step block.
package lrk_pkg;

    localparam int unsigned COORD_W           = 32;
    localparam int unsigned TRAJ_FIELD_W      = 3;
    localparam int unsigned STEP_W            = 21;
    localparam int unsigned GAIN_W            = 31;
    localparam int unsigned BETA_W            = 32;
    localparam int unsigned CFG_IDX_W         = 2;
    localparam int unsigned MUL_A_W           = 36;
    localparam int unsigned MUL_B_W           = 33;
    localparam int unsigned PROD_W            = MUL_A_W + MUL_B_W;
    localparam int unsigned S_TDATA_W         = 104;
    localparam int unsigned M_TDATA_W         = 104;
    localparam int unsigned DEF_TRAJECTORIES  = 8;
    localparam int unsigned DEF_FRACTION_BITS = 20;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP  = 2'd0,
        CFG_SIGMA = 2'd1,
        CFG_RHO   = 2'd2,
        CFG_BETA  = 2'd3
    } t_cfg_reg;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_ISSUE,
        S_MWAIT,
        S_DIV,
        S_WB
    } t_state;

    // Multiplication slots within one stage of the step.
    typedef enum logic [2:0] {
        SUB_SIGMA = 3'd0,
        SUB_RHO   = 3'd1,
        SUB_XZ    = 3'd2,
        SUB_BETA  = 3'd3,
        SUB_XY    = 3'd4,
        SUB_AX    = 3'd5,
        SUB_AY    = 3'd6,
        SUB_AZ    = 3'd7
    } t_sub;

    typedef struct packed {
        logic                      ov;
        logic signed [COORD_W-1:0] val;
    } t_sat;

    // Saturate a wide signed value to a coordinate, flagging any clipping.
    function automatic t_sat sat_coord(input logic signed [PROD_W-1:0] v);
        t_sat r;
        logic [PROD_W-COORD_W:0] hi;
        hi = v[PROD_W-1:COORD_W-1];
        if ((hi == '0) || (hi == '1)) begin
            r.ov  = 1'b0;
            r.val = v[COORD_W-1:0];
        end else begin
            r.ov  = 1'b1;
            r.val = v[PROD_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/lorenz_rk4_step.sv =====
// A load item or an out-of-range item goes from its beat straight to the write-back state.
// A step item takes 32 products on the one bit-serial multiplier, plus three serial
// divisions by six, before write-back. One item is in work at a time.
// Reset clears the point store (valid bits), the sequencer and the output register,
// and loads the default dt, sigma, rho and beta.
module lorenz_rk4_step #(
    parameter int unsigned TRAJECTORIES  = lrk_pkg::DEF_TRAJECTORIES,
    parameter int unsigned FRACTION_BITS = lrk_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input item: tdata = trajectory[2:0], load_x, load_y, load_z, zero pad.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [lrk_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // tuser = mode (0 load, 1 step).
    input  logic                              i_s_tuser,
    // Result: tdata = which_trajectory[2:0], point_x, point_y, point_z, overflow, zero pad.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [lrk_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lrk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    `include "assert_macros.svh"

    localparam int unsigned IDX_W  = (TRAJECTORIES > 1) ? $clog2(TRAJECTORIES) : 1;
    localparam int unsigned DW     = 58 - FRACTION_BITS;
    localparam int unsigned DCNT_W = $clog2(DW + 1);
    localparam int unsigned CW     = lrk_pkg::COORD_W;
    localparam int unsigned PW     = lrk_pkg::PROD_W;
    localparam int unsigned AW     = lrk_pkg::MUL_A_W;
    localparam int unsigned BW     = lrk_pkg::MUL_B_W;

    localparam logic [63:0] STEP_RST64  = ((64'd5 << FRACTION_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] SIGMA_RST64 = 64'd10 << FRACTION_BITS;
    localparam logic [63:0] RHO_RST64   = 64'd28 << FRACTION_BITS;
    localparam logic [63:0] BETA_MAG64  = ((64'd16 << FRACTION_BITS) + 64'd3) / 64'd6;
    localparam logic [63:0] BETA_RST64  = 64'd0 - BETA_MAG64;

    // Configuration registers.
    logic [lrk_pkg::STEP_W-1:0]        r_step;
    logic [lrk_pkg::GAIN_W-1:0]        r_sigma;
    logic [lrk_pkg::GAIN_W-1:0]        r_rho;
    logic signed [lrk_pkg::BETA_W-1:0] r_beta;

    // Point store.
    logic [CW-1:0]           r_mem_x [TRAJECTORIES];
    logic [CW-1:0]           r_mem_y [TRAJECTORIES];
    logic [CW-1:0]           r_mem_z [TRAJECTORIES];
    logic [TRAJECTORIES-1:0] r_valid;
    logic [CW-1:0]           r_rd_x, r_rd_y, r_rd_z;
    logic                    r_rd_v;

    // Item and datapath registers.
    lrk_pkg::t_state         r_state, n_state;
    logic [lrk_pkg::TRAJ_FIELD_W-1:0] r_traj;
    logic                    r_inrange;
    logic                    r_ov;
    logic [4:0]              r_uop;
    logic signed [CW-1:0]    r_p [3];
    logic signed [CW-1:0]    r_q [3];
    logic signed [CW-1:0]    r_k [3];
    logic signed [AW-1:0]    r_s [3];
    logic signed [CW-1:0]    r_t1;
    logic [DW-1:0]           r_dn;
    logic [2:0]              r_drem;
    logic                    r_dneg;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_out_valid;
    logic [lrk_pkg::M_TDATA_W-1:0] r_out_data;

    // Input fields.
    logic [lrk_pkg::TRAJ_FIELD_W-1:0] in_traj;
    logic [CW-1:0]           in_x, in_y, in_z;
    logic [IDX_W-1:0]        in_idx;
    logic                    in_range;
    logic                    in_accept;
    logic [IDX_W-1:0]        wr_idx;

    // Control.
    logic                    mul_start;
    logic                    mul_done;
    logic                    out_load;
    logic                    out_free;
    logic                    div_fin;

    // Datapath combinational values.
    lrk_pkg::t_sub           sub;
    logic [1:0]              stage;
    logic [1:0]              axis;
    lrk_pkg::t_sat           diff_s, mq, mh, ma, ky_s, kz_s, adv_s, fin_s;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    mul_prod;
    logic signed [PW-1:0]    prod_f;
    logic                    k_we, t1_we, q_we, div_go, step_ov;
    logic [1:0]              k_idx;
    logic signed [CW-1:0]    k_val;
    logic signed [AW-1:0]    k_ext;
    logic signed [AW-1:0]    s_upd;
    logic signed [DW-1:0]    div_qt;
    logic [DW-1:0]           div_mag;
    logic [3:0]              div_t;
    logic                    div_ge;
    logic [2:0]              div_rem_n;
    logic signed [DW:0]      div_inc;

    assign in_traj   = i_s_tdata[2:0];
    assign in_x      = i_s_tdata[34:3];
    assign in_y      = i_s_tdata[66:35];
    assign in_z      = i_s_tdata[98:67];
    assign in_idx    = IDX_W'(in_traj);
    assign in_range  = (9'(in_traj) < 9'(TRAJECTORIES));
    assign in_accept = i_s_tvalid && o_s_tready;
    assign wr_idx    = IDX_W'(r_traj);
    assign out_free  = !r_out_valid || i_m_tready;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RST64[lrk_pkg::STEP_W-1:0];
            r_sigma <= SIGMA_RST64[lrk_pkg::GAIN_W-1:0];
            r_rho   <= RHO_RST64[lrk_pkg::GAIN_W-1:0];
            r_beta  <= BETA_RST64[lrk_pkg::BETA_W-1:0];
        end else if (i_cfg_valid) begin
            unique case (lrk_pkg::t_cfg_reg'(i_cfg_index))
                lrk_pkg::CFG_STEP:  r_step  <= i_cfg_data[lrk_pkg::STEP_W-1:0];
                lrk_pkg::CFG_SIGMA: r_sigma <= i_cfg_data[lrk_pkg::GAIN_W-1:0];
                lrk_pkg::CFG_RHO:   r_rho   <= i_cfg_data[lrk_pkg::GAIN_W-1:0];
                lrk_pkg::CFG_BETA:  r_beta  <= i_cfg_data;
            endcase
        end
    end

    // Shared bit-serial multiplier.
    lrk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrk_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control outputs.
    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            lrk_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = (i_s_tuser && in_range) ? lrk_pkg::S_FETCH : lrk_pkg::S_WB;
                end
            end
            lrk_pkg::S_FETCH: begin
                n_state = lrk_pkg::S_ISSUE;
            end
            lrk_pkg::S_ISSUE: begin
                mul_start = 1'b1;
                n_state   = lrk_pkg::S_MWAIT;
            end
            lrk_pkg::S_MWAIT: begin
                if (mul_done) begin
                    n_state = div_go ? lrk_pkg::S_DIV : lrk_pkg::S_ISSUE;
                end
            end
            lrk_pkg::S_DIV: begin
                if (div_fin) begin
                    n_state = (r_uop == 5'd31) ? lrk_pkg::S_WB : lrk_pkg::S_ISSUE;
                end
            end
            lrk_pkg::S_WB: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = lrk_pkg::S_IDLE;
                end
            end
            default: n_state = lrk_pkg::S_IDLE;
        endcase
    end

    // Operand selection and result shaping for the current slot.
    always_comb begin
        sub    = lrk_pkg::t_sub'(r_uop[2:0]);
        stage  = r_uop[4:3];
        axis   = 2'(r_uop[2:0] - 3'(lrk_pkg::SUB_AX));
        diff_s = lrk_pkg::sat_coord(PW'(r_q[1]) - PW'(r_q[0]));

        unique case (sub)
            lrk_pkg::SUB_SIGMA: begin mul_a = AW'(diff_s.val); mul_b = BW'(r_sigma); end
            lrk_pkg::SUB_RHO:   begin mul_a = AW'(r_q[0]);     mul_b = BW'(r_rho);   end
            lrk_pkg::SUB_XZ:    begin mul_a = AW'(r_q[2]);     mul_b = BW'(r_q[0]);  end
            lrk_pkg::SUB_BETA:  begin mul_a = AW'(r_q[2]);     mul_b = BW'(r_beta);  end
            lrk_pkg::SUB_XY:    begin mul_a = AW'(r_q[1]);     mul_b = BW'(r_q[0]);  end
            lrk_pkg::SUB_AX,
            lrk_pkg::SUB_AY,
            lrk_pkg::SUB_AZ: begin
                mul_a = (stage == 2'd3) ? r_s[axis] : AW'(r_k[axis]);
                mul_b = BW'(r_step);
            end
        endcase

        prod_f = mul_prod >>> FRACTION_BITS;
        mq     = lrk_pkg::sat_coord(prod_f);
        mh     = lrk_pkg::sat_coord(mul_prod >>> (FRACTION_BITS + 1));
        ma     = (stage == 2'd2) ? mq : mh;
        ky_s   = lrk_pkg::sat_coord(PW'(r_t1) - PW'(r_q[1]) - PW'(mq.val));
        kz_s   = lrk_pkg::sat_coord(PW'(r_t1) + PW'(mq.val));
        adv_s  = lrk_pkg::sat_coord(PW'(r_p[axis]) + PW'(ma.val));

        k_we    = 1'b0;
        t1_we   = 1'b0;
        q_we    = 1'b0;
        div_go  = 1'b0;
        k_idx   = 2'd0;
        k_val   = mq.val;
        step_ov = 1'b0;
        unique case (sub)
            lrk_pkg::SUB_SIGMA: begin
                k_we = 1'b1; k_idx = 2'd0; k_val = mq.val; step_ov = mq.ov;
            end
            lrk_pkg::SUB_RHO: begin
                t1_we = 1'b1; step_ov = mq.ov;
            end
            lrk_pkg::SUB_XZ: begin
                k_we = 1'b1; k_idx = 2'd1; k_val = ky_s.val; step_ov = mq.ov | ky_s.ov;
            end
            lrk_pkg::SUB_BETA: begin
                t1_we = 1'b1; step_ov = mq.ov;
            end
            lrk_pkg::SUB_XY: begin
                k_we = 1'b1; k_idx = 2'd2; k_val = kz_s.val; step_ov = mq.ov | kz_s.ov;
            end
            lrk_pkg::SUB_AX,
            lrk_pkg::SUB_AY,
            lrk_pkg::SUB_AZ: begin
                if (stage == 2'd3) begin
                    div_go = 1'b1;
                end else begin
                    q_we    = 1'b1;
                    step_ov = ma.ov | adv_s.ov;
                end
            end
        endcase

        // Weighted sum k1 + 2k2 + 2k3 + k4, built as each derivative lands.
        k_ext = AW'(k_val);
        if (stage == 2'd0) begin
            s_upd = k_ext;
        end else if (stage == 2'd3) begin
            s_upd = r_s[k_idx] + k_ext;
        end else begin
            s_upd = r_s[k_idx] + (k_ext <<< 1);
        end

        // Floor division by six: divide the magnitude, biased for negative values.
        div_qt    = prod_f[DW-1:0];
        div_mag   = div_qt[DW-1] ? (~div_qt + DW'(6)) : div_qt;
        div_t     = {r_drem, r_dn[DW-1]};
        div_ge    = (div_t >= 4'd6);
        div_rem_n = div_ge ? 3'(div_t - 4'd6) : div_t[2:0];
        div_inc   = r_dneg ? -$signed({1'b0, r_dn}) : $signed({1'b0, r_dn});
        fin_s     = lrk_pkg::sat_coord(PW'(r_p[axis]) + PW'(div_inc));
        div_fin   = (r_state == lrk_pkg::S_DIV) && (r_dcnt == DCNT_W'(DW));
    end

    // Store read at the beat, write at the end of the item.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_x <= r_mem_x[in_idx];
            r_rd_y <= r_mem_y[in_idx];
            r_rd_z <= r_mem_z[in_idx];
        end
        if (out_load && r_inrange) begin
            r_mem_x[wr_idx] <= r_p[0];
            r_mem_y[wr_idx] <= r_p[1];
            r_mem_z[wr_idx] <= r_p[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_rd_v <= r_valid[in_idx];
            end
            if (out_load && r_inrange) begin
                r_valid[wr_idx] <= 1'b1;
            end
        end
    end

    // Sequencer counters and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uop  <= '0;
            r_ov   <= 1'b0;
            r_dcnt <= '0;
        end else begin
            unique case (r_state)
                lrk_pkg::S_IDLE: begin
                    r_ov  <= 1'b0;
                    r_uop <= '0;
                end
                lrk_pkg::S_ISSUE: begin
                    if (sub == lrk_pkg::SUB_SIGMA) begin
                        r_ov <= r_ov | diff_s.ov;
                    end
                end
                lrk_pkg::S_MWAIT: begin
                    if (mul_done) begin
                        r_ov <= r_ov | step_ov;
                        if (div_go) begin
                            r_dcnt <= '0;
                        end else begin
                            r_uop <= r_uop + 5'd1;
                        end
                    end
                end
                lrk_pkg::S_DIV: begin
                    if (div_fin) begin
                        r_ov  <= r_ov | fin_s.ov;
                        r_uop <= r_uop + 5'd1;
                    end else begin
                        r_dcnt <= r_dcnt + DCNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Point, derivative and divider registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lrk_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    r_traj    <= in_traj;
                    r_inrange <= in_range;
                    if (in_range && !i_s_tuser) begin
                        r_p[0] <= in_x;
                        r_p[1] <= in_y;
                        r_p[2] <= in_z;
                    end else begin
                        r_p[0] <= '0;
                        r_p[1] <= '0;
                        r_p[2] <= '0;
                    end
                end
            end
            lrk_pkg::S_FETCH: begin
                r_p[0] <= r_rd_v ? r_rd_x : '0;
                r_p[1] <= r_rd_v ? r_rd_y : '0;
                r_p[2] <= r_rd_v ? r_rd_z : '0;
                r_q[0] <= r_rd_v ? r_rd_x : '0;
                r_q[1] <= r_rd_v ? r_rd_y : '0;
                r_q[2] <= r_rd_v ? r_rd_z : '0;
            end
            lrk_pkg::S_MWAIT: begin
                if (mul_done) begin
                    if (k_we) begin
                        r_k[k_idx] <= k_val;
                        r_s[k_idx] <= s_upd;
                    end
                    if (t1_we) begin
                        r_t1 <= mq.val;
                    end
                    if (q_we) begin
                        r_q[axis] <= adv_s.val;
                    end
                    if (div_go) begin
                        r_dn   <= div_mag;
                        r_drem <= '0;
                        r_dneg <= div_qt[DW-1];
                    end
                end
            end
            lrk_pkg::S_DIV: begin
                if (div_fin) begin
                    r_p[axis] <= fin_s.val;
                end else begin
                    r_dn   <= {r_dn[DW-2:0], div_ge};
                    r_drem <= div_rem_n;
                end
            end
            default: ;
        endcase
    end

    // Output register: holds a finished result until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {4'd0, r_ov, r_p[2], r_p[1], r_p[0], r_traj};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks on the sequencer.
    `ASSERT_IMPLIES(a_mul_done_in_wait, i_clk, i_rst_n, mul_done, r_state == lrk_pkg::S_MWAIT, "multiplier finished outside the wait state")
    `ASSERT_IMPLIES(a_div_last_slot, i_clk, i_rst_n, div_fin && (r_uop == 5'd31), n_state == lrk_pkg::S_WB, "last division did not end the step")
    `ASSERT_IMPLIES(a_out_slot_free, i_clk, i_rst_n, out_load, !r_out_valid || i_m_tready, "result overwrote a beat not yet taken")
    `ASSERT_NEXT(a_load_no_ov, i_clk, i_rst_n, in_accept && !i_s_tuser, !r_ov, "load item raised overflow")

endmodule

// ===== rtl/core/lrk_mul.sv =====
// Bit-serial signed shift-and-add multiplier, one multiplier bit per cycle.
module lrk_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lrk_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [lrk_pkg::MUL_B_W-1:0]  i_b,
    output logic                                o_done,
    output logic signed [lrk_pkg::PROD_W-1:0]   o_prod
);

    localparam int unsigned CNT_W = $clog2(lrk_pkg::MUL_B_W + 1);

    logic signed [lrk_pkg::MUL_A_W-1:0] r_a;
    logic signed [lrk_pkg::MUL_A_W:0]   r_hi;
    logic        [lrk_pkg::MUL_B_W-1:0] r_lo;
    logic        [CNT_W-1:0]            r_cnt;
    logic                               r_busy;
    logic                               r_done;

    logic signed [lrk_pkg::MUL_A_W:0]   a_ext;
    logic signed [lrk_pkg::MUL_A_W:0]   psum;
    logic                               last;

    // Add or, for the sign bit of the multiplier, subtract the multiplicand.
    always_comb begin
        a_ext = (lrk_pkg::MUL_A_W + 1)'(r_a);
        last  = (r_cnt == CNT_W'(lrk_pkg::MUL_B_W - 1));
        if (r_lo[0]) begin
            psum = last ? (r_hi - a_ext) : (r_hi + a_ext);
        end else begin
            psum = r_hi;
        end
    end

    // Shift the partial product right by one bit each cycle while busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= {psum[lrk_pkg::MUL_A_W], psum[lrk_pkg::MUL_A_W:1]};
            r_lo <= {psum[0], r_lo[lrk_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[lrk_pkg::MUL_A_W-1:0], r_lo};

endmodule

// ===== bench/lrk_step_checker.sv =====
// Checker for the Lorenz RK4 step block: watches the channels, predicts and compares results.
`timescale 1ns / 100ps

module lrk_step_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [103:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [103:0] i_m_tdata,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    localparam int FRAC = 20;

    typedef struct {
        logic [2:0]  traj;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        ov;
    } t_point_result;

    typedef longint t_triple[3];

    t_point_result expected_points[$];

    logic [20:0]        dt_q;
    logic [30:0]        sigma_q;
    logic [30:0]        rho_q;
    logic signed [31:0] beta_q;
    logic signed [31:0] store_x[8];
    logic signed [31:0] store_y[8];
    logic signed [31:0] store_z[8];
    bit                 clipped;
    int                 fails;

    // Clip to 32-bit signed and remember that clipping happened.
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Fixed-point product, floored by the arithmetic shift.
    function automatic longint qmul(longint a, longint b, int sh);
        return clip32((a * b) >>> sh);
    endfunction

    function automatic longint floor_div(longint p, longint d);
        if (p >= 0)
            return p / d;
        return -((-p + d - 1) / d);
    endfunction

    // Lorenz derivatives at one point.
    function automatic t_triple lorenz_slope(t_triple p);
        t_triple d;
        longint  sg;
        longint  rh;
        longint  bt;
        sg = sigma_q;
        rh = rho_q;
        bt = beta_q;
        d[0] = qmul(sg, clip32(p[1] - p[0]), FRAC);
        d[1] = clip32(qmul(rh, p[0], FRAC) - p[1] - qmul(p[0], p[2], FRAC));
        d[2] = clip32(qmul(bt, p[2], FRAC) + qmul(p[0], p[1], FRAC));
        return d;
    endfunction

    // Point moved along slope k by dt scaled down by 2^sh.
    function automatic t_triple nudge(t_triple p, t_triple k, int sh);
        t_triple q;
        longint  h;
        h = dt_q;
        for (int i = 0; i < 3; i++)
            q[i] = clip32(p[i] + qmul(h, k[i], sh));
        return q;
    endfunction

    // One classical RK4 step of a point.
    function automatic t_triple rk4_advance(t_triple p);
        t_triple k1, k2, k3, k4, r;
        longint  h;
        longint  sum;
        h  = dt_q;
        k1 = lorenz_slope(p);
        k2 = lorenz_slope(nudge(p, k1, FRAC + 1));
        k3 = lorenz_slope(nudge(p, k2, FRAC + 1));
        k4 = lorenz_slope(nudge(p, k3, FRAC));
        for (int i = 0; i < 3; i++) begin
            sum  = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
            r[i] = clip32(p[i] + floor_div(h * sum, 64'sd6 <<< FRAC));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_point_result exp_pt;
        t_point_result got_pt;
        t_triple       p;
        logic [2:0]    t;
        if (!i_rst_n) begin
            dt_q    = 21'd5243;
            sigma_q = 31'd10485760;
            rho_q   = 31'd29360128;
            beta_q  = -32'sd2796203;
            for (int i = 0; i < 8; i++) begin
                store_x[i] = '0;
                store_y[i] = '0;
                store_z[i] = '0;
            end
            expected_points.delete();
            fails = 0;
        end else begin
            // Register writes update the predictor's copy.
            if (i_cfg_valid && i_cfg_ready) begin
                case (lrk_pkg::t_cfg_reg'(i_cfg_index))
                    lrk_pkg::CFG_STEP:  dt_q    = i_cfg_data[20:0];
                    lrk_pkg::CFG_SIGMA: sigma_q = i_cfg_data[30:0];
                    lrk_pkg::CFG_RHO:   rho_q   = i_cfg_data[30:0];
                    lrk_pkg::CFG_BETA:  beta_q  = i_cfg_data;
                    default: ;
                endcase
            end
            // Each accepted input beat yields one expected point.
            if (i_s_tvalid && i_s_tready) begin
                t       = i_s_tdata[2:0];
                clipped = 1'b0;
                if (!i_s_tuser) begin
                    p[0] = longint'($signed(i_s_tdata[34:3]));
                    p[1] = longint'($signed(i_s_tdata[66:35]));
                    p[2] = longint'($signed(i_s_tdata[98:67]));
                end else begin
                    p[0] = store_x[t];
                    p[1] = store_y[t];
                    p[2] = store_z[t];
                    p    = rk4_advance(p);
                end
                store_x[t] = p[0][31:0];
                store_y[t] = p[1][31:0];
                store_z[t] = p[2][31:0];
                exp_pt.traj = t;
                exp_pt.x    = p[0][31:0];
                exp_pt.y    = p[1][31:0];
                exp_pt.z    = p[2][31:0];
                exp_pt.ov   = clipped;
                expected_points.push_back(exp_pt);
            end
            // Each result beat is compared with the oldest expectation.
            if (i_m_tvalid && i_m_tready) begin
                got_pt.traj = i_m_tdata[2:0];
                got_pt.x    = i_m_tdata[34:3];
                got_pt.y    = i_m_tdata[66:35];
                got_pt.z    = i_m_tdata[98:67];
                got_pt.ov   = i_m_tdata[99];
                if (expected_points.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: traj %0d", got_pt.traj);
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (got_pt.traj !== exp_pt.traj || got_pt.x !== exp_pt.x ||
                        got_pt.y !== exp_pt.y || got_pt.z !== exp_pt.z ||
                        got_pt.ov !== exp_pt.ov) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp t%0d %h %h %h ov%b, got t%0d %h %h %h ov%b",
                                     exp_pt.traj, exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.ov,
                                     got_pt.traj, got_pt.x, got_pt.y, got_pt.z, got_pt.ov);
                    end
                end
            end
        end
        o_pending    <= expected_points.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_lorenz_rk4_step.sv =====
// Testbench top for the Lorenz RK4 step block: stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps

module tb_lorenz_rk4_step;

    localparam int LIMIT_CYCLES = 12000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [103:0] s_data;
    logic         s_user;
    logic         m_valid;
    logic         m_ready;
    logic [103:0] m_data;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           fail_count;
    int           pending;
    bit           quiet;
    int           hold_req;
    int           hold_seen;
    int           hold_cnt;
    int           stall_cnt;
    int           cycles;

    lorenz_rk4_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lrk_step_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the cycle count.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stall bursts, plus long hold-offs on request.
    initial begin
        hold_req  = 0;
        hold_seen = 0;
        hold_cnt  = 0;
        stall_cnt = 0;
    end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= 400;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= (hold_cnt == 1);
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_ready   <= (stall_cnt == 1);
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_cnt <= $urandom_range(1, 12);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item and hold it until its beat, then maybe idle.
    task automatic send_point(input bit mode, input logic [2:0] traj,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        s_valid <= 1'b1;
        s_user  <= mode;
        s_data  <= {5'b0, z, y, x, traj};
        do @(posedge i_clk); while (!s_ready);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Sender pause until every expected point has come back.
    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(input lrk_pkg::t_cfg_reg idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all four registers; unused upper bits carry random noise.
    task automatic set_gains(input logic [20:0] dt, input logic [30:0] sg,
                             input logic [30:0] rh, input logic [31:0] bt);
        drain();
        write_reg(lrk_pkg::CFG_STEP, {11'($urandom_range(0, 2047)), dt});
        write_reg(lrk_pkg::CFG_SIGMA, {1'($urandom_range(0, 1)), sg});
        write_reg(lrk_pkg::CFG_RHO, {1'($urandom_range(0, 1)), rh});
        write_reg(lrk_pkg::CFG_BETA, bt);
    endtask

    function automatic logic [31:0] pick_coord();
        if ($urandom_range(0, 9) < 6)
            return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
        return $urandom;
    endfunction

    // Random items: loads seed trajectories, steps walk them along the attractor.
    task automatic random_items(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 30)
                send_point(1'b1, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
            else
                send_point(1'b0, 3'($urandom_range(0, 7)), pick_coord(), pick_coord(),
                           pick_coord());
        end
    endtask

    initial begin
        quiet     = 1'b0;
        i_rst_n   = 1'b0;
        s_valid   = 1'b0;
        s_user    = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = lrk_pkg::CFG_STEP;
        cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, never-loaded trajectory, saturating steps.
        send_point(1'b1, 3'd5, $urandom, $urandom, $urandom);
        send_point(1'b0, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(1'b1, 3'd0, '0, '0, '0);
        send_point(1'b0, 3'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(1'b1, 3'd1, '0, '0, '0);
        send_point(1'b0, 3'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(1'b1, 3'd2, '0, '0, '0);
        send_point(1'b0, 3'd3, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
        send_point(1'b1, 3'd3, '0, '0, '0);
        send_point(1'b1, 3'd3, '0, '0, '0);
        send_point(1'b0, 3'd7, 32'hFFF0_0000, 32'h0200_0000, 32'h0180_0000);
        send_point(1'b1, 3'd7, '0, '0, '0);

        // Long result hold-off while loads keep coming, so the input stalls.
        hold_req = hold_req + 1;
        for (int i = 0; i < 6; i++)
            send_point(1'b0, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
        drain();

        random_items(650);
        set_gains(21'd1048576, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(1'b1, 3'd3, '0, '0, '0);
        random_items(180);
        set_gains(21'd0, 31'd0, 31'd0, 32'h8000_0000);
        random_items(150);
        set_gains(21'($urandom_range(0, 20000)), 31'($urandom_range(0, 32'h0400_0000)),
                  31'($urandom_range(0, 32'h0400_0000)), $urandom);
        random_items(250);
        set_gains(21'($urandom_range(0, 1048576)), 31'($urandom), 31'($urandom), $urandom);
        random_items(200);
        set_gains(21'd5243, 31'd10485760, 31'd29360128, -32'sd2796203);
        random_items(60);
        quiet = 1'b1;
        random_items(300);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
